[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL. Define ASSERT_OFF to drop
// all of them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[hw/rtl/gfba_pkg.sv]
// ----------------------------------------------------------------------------
// Grouped free block allocator package
// Request and response beat types, command and status codes, defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package gfba_pkg;

  localparam int IdW  = 10;
  localparam int CntW = 11;
  localparam int StW  = 2;

  localparam int BlocksDef  = 1024;
  localparam int EntriesDef = 16;

  localparam logic [IdW-1:0] NumBlocksRst = 10'd1023;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [StW-1:0] ST_OK      = 2'd0;
  localparam logic [StW-1:0] ST_NONE    = 2'd1;
  localparam logic [StW-1:0] ST_CORRUPT = 2'd2;

  typedef struct packed {
    logic           cmd;
    logic [IdW-1:0] blk_id;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0] granted_id;
    logic [StW-1:0] status;
  } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/grouped_free_block_allocator.sv]
// ----------------------------------------------------------------------------
// Grouped free block allocator
// Allocates and frees storage blocks through a chain of index blocks that is
// kept in a single-port-write, registered-read index word memory.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   request   start & !busy              req_i  (cmd, blk_id)
//   response  done_o, one cycle          rsp_o  (granted_id, status)
//   config    cfg_valid_i & cfg_ready_o  cfg_data_i (num_blocks)
//
// An allocate on an empty list answers in the cycle after the start beat; a
// free on an empty list answers once the new head block is written. Otherwise
// the head block is scanned one word a cycle through the memory read port: a
// hit answers from the scan, an allocate with no filled slot from the link
// state, a free into a full head once the freed block is written as new head.
// Reset initialises the control, head, count and limit registers only; the
// index memory needs no clearing pass. The receiver cannot stall the response.
//
`default_nettype none

module grouped_free_block_allocator #(
  parameter int BLOCKS  = gfba_pkg::BlocksDef,
  parameter int ENTRIES = gfba_pkg::EntriesDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire gfba_pkg::req_t           req_i,
  output logic                          done_o,
  output gfba_pkg::rsp_t                rsp_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [gfba_pkg::IdW-1:0] cfg_data_i
);

  import gfba_pkg::*;

  `include "assert_macros.svh"

  localparam int BW    = $clog2(BLOCKS);
  localparam int EW    = $clog2(ENTRIES);
  localparam int AW    = $clog2(BLOCKS * ENTRIES);
  localparam int Depth = BLOCKS * ENTRIES;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;
  localparam logic [1:0] S_FILL = 2'd3;

  localparam logic [EW-1:0] LastWord = EW'(ENTRIES - 1);

  // Index block of a block id: id mod BLOCKS by shifted compare and subtract.
  function automatic logic [BW-1:0] blk_idx(logic [IdW-1:0] id);
    logic [IdW-1:0] r;
    r = id;
    for (int k = 6; k >= 0; k--) begin
      if ((BLOCKS << k) < 1024) begin
        if (r >= IdW'(BLOCKS << k)) begin
          r = r - IdW'(BLOCKS << k);
        end
      end
    end
    return BW'(r);
  endfunction

  logic [1:0]      state_q, state_d;
  logic [EW-1:0]   w_q, w_d;
  logic [IdW-1:0]  head_q, head_d;
  logic [BW-1:0]   hidx_q, hidx_d;
  logic            hvalid_q, hvalid_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdW-1:0]  link_q, link_d;
  logic [IdW-1:0]  num_q;
  req_t            item_q, item_d;
  rsp_t            rsp_q, rsp_d;
  logic            done_q, done_d;

  logic [IdW-1:0]  mem [Depth];
  logic [IdW-1:0]  rdata_q;
  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_raddr, mem_waddr;
  logic [IdW-1:0]  mem_wdata;

  logic [AW-1:0]   head_base;
  logic            list_empty;
  logic            is_alloc;
  logic            hit;

  assign head_base  = AW'(hidx_q) * AW'(ENTRIES);
  assign list_empty = !hvalid_q || (cnt_q == '0);
  assign is_alloc   = (item_q.cmd == CMD_ALLOC);
  assign hit        = is_alloc ? (rdata_q != '0) : (rdata_q == '0);

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d   = state_q;
    w_d       = w_q;
    head_d    = head_q;
    hidx_d    = hidx_q;
    hvalid_d  = hvalid_q;
    cnt_d     = cnt_q;
    link_d    = link_q;
    item_d    = item_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = head_base;
    mem_we    = 1'b0;
    mem_waddr = head_base;
    mem_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d = req_i;
          if (list_empty) begin
            if (req_i.cmd == CMD_ALLOC) begin
              hvalid_d         = 1'b0;
              head_d           = '0;
              hidx_d           = '0;
              cnt_d            = '0;
              done_d           = 1'b1;
              rsp_d.granted_id = '0;
              rsp_d.status     = ST_NONE;
            end else begin
              // The freed block starts a new chain and links to itself.
              head_d   = req_i.blk_id;
              hidx_d   = blk_idx(req_i.blk_id);
              hvalid_d = 1'b1;
              cnt_d    = CntW'(1);
              link_d   = req_i.blk_id;
              w_d      = '0;
              state_d  = S_FILL;
            end
          end else begin
            mem_re    = 1'b1;
            mem_raddr = head_base + AW'(1);
            w_d       = EW'(1);
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // rdata_q holds word w_q of the head block.
        if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = head_base + AW'(w_q);
          done_d    = 1'b1;
          state_d   = S_IDLE;
          if (is_alloc) begin
            mem_wdata        = '0;
            cnt_d            = cnt_q - CntW'(1);
            rsp_d.granted_id = rdata_q;
            rsp_d.status     = (rdata_q > num_q) ? ST_CORRUPT : ST_OK;
          end else begin
            mem_wdata        = item_q.blk_id;
            cnt_d            = cnt_q + CntW'(1);
            rsp_d.granted_id = '0;
            rsp_d.status     = ST_OK;
          end
        end else if (w_q == LastWord) begin
          if (is_alloc) begin
            mem_re    = 1'b1;
            mem_raddr = head_base;
            state_d   = S_LINK;
          end else begin
            // Head is full: the freed block becomes head, linking to the old one.
            head_d  = item_q.blk_id;
            hidx_d  = blk_idx(item_q.blk_id);
            link_d  = head_q;
            cnt_d   = cnt_q + CntW'(1);
            w_d     = '0;
            state_d = S_FILL;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = head_base + AW'(w_q) + AW'(1);
          w_d       = w_q + EW'(1);
        end
      end

      S_LINK: begin
        // No filled slot: grant the head block itself and follow its link.
        rsp_d.granted_id = head_q;
        rsp_d.status     = (head_q > num_q) ? ST_CORRUPT : ST_OK;
        done_d           = 1'b1;
        state_d          = S_IDLE;
        if (rdata_q == head_q) begin
          cnt_d    = '0;
          hvalid_d = 1'b0;
          head_d   = '0;
          hidx_d   = '0;
        end else begin
          cnt_d  = cnt_q - CntW'(1);
          head_d = rdata_q;
          hidx_d = blk_idx(rdata_q);
        end
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = head_base + AW'(w_q);
        mem_wdata = (w_q == '0) ? link_q : '0;
        if (w_q == LastWord) begin
          rsp_d.granted_id = '0;
          rsp_d.status     = ST_OK;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end else begin
          w_d = w_q + EW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      w_q      <= '0;
      head_q   <= '0;
      hidx_q   <= '0;
      hvalid_q <= 1'b0;
      cnt_q    <= '0;
      num_q    <= NumBlocksRst;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      w_q      <= w_d;
      head_q   <= head_d;
      hidx_q   <= hidx_d;
      hvalid_q <= hvalid_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    link_q <= link_d;
    item_q <= item_d;
    rsp_q  <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // The scan never writes and reads the index memory in the same cycle.
  `ASSERT_NEVER(a_no_rw_overlap, clk_i, rst_ni, mem_we && mem_re, "read and write overlap")
  // A response is only given once the sequencer is back in idle.
  `ASSERT_AT(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "response while busy")
  // Following the link always answers in the next cycle.
  `ASSERT_AT(a_link_done, clk_i, rst_ni, (state_q == S_LINK) |=> done_o, "link without response")
  // An empty list always carries head block zero.
  `ASSERT_AT(a_empty_head, clk_i, rst_ni, !hvalid_q |-> (head_q == '0), "empty list with head")

endmodule

`default_nettype wire

[tb/tb_grouped_free_block_allocator.sv]
// ----------------------------------------------------------------------------
// Grouped free block allocator testbench
// Drives allocate and free commands with random gaps and changes the block
// limit between phases. A scoreboard keeps its own copy of the index chain
// and compares every response beat with the grant it expects.
// ----------------------------------------------------------------------------
module tb_grouped_free_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import gfba_pkg::*;

  localparam int Entries      = EntriesDef;
  localparam int SettleCycles = 2 * EntriesDef + 8;
  localparam int WatchdogMax  = 2000;
  localparam int PhaseItems   = 110;
  localparam int MaxReports   = 10;

  // Scoreboard: mirrors the free list and holds the grants still to come.
  class alloc_checker;
    logic [IdW-1:0]  idx_mem [BlocksDef*EntriesDef];
    logic [IdW-1:0]  head_blk;
    logic            head_ok;
    logic [CntW-1:0] free_cnt;
    logic [IdW-1:0]  limit;
    rsp_t            pending_grants [$];
    int unsigned     fail_cnt;

    function new();
      head_blk = '0;
      head_ok  = 1'b0;
      free_cnt = '0;
      limit    = NumBlocksRst;
      fail_cnt = 0;
    endfunction

    function int unsigned pending();
      return pending_grants.size();
    endfunction

    function void set_limit(logic [IdW-1:0] v);
      limit = v;
    endfunction

    function logic [IdW-1:0] rd_word(logic [IdW-1:0] blk, int w);
      return idx_mem[int'(blk) * Entries + w];
    endfunction

    function void wr_word(logic [IdW-1:0] blk, int w, logic [IdW-1:0] v);
      idx_mem[int'(blk) * Entries + w] = v;
    endfunction

    // A block becomes head: link word first, all slots empty.
    function void build_head(logic [IdW-1:0] blk, logic [IdW-1:0] link);
      wr_word(blk, 0, link);
      for (int w = 1; w < Entries; w++) wr_word(blk, w, '0);
    endfunction

    function void note_request(req_t r);
      rsp_t           exp;
      bit             hit;
      logic [IdW-1:0] link;
      exp = '0;
      exp.status = ST_OK;
      hit = 1'b0;
      if (r.cmd == CMD_ALLOC) begin
        if (!head_ok || free_cnt == 0) begin
          head_ok  = 1'b0;
          head_blk = '0;
          free_cnt = '0;
          exp.status = ST_NONE;
        end else begin
          free_cnt = free_cnt - CntW'(1);
          for (int w = 1; w < Entries && !hit; w++) begin
            if (rd_word(head_blk, w) != '0) begin
              exp.granted_id = rd_word(head_blk, w);
              wr_word(head_blk, w, '0);
              hit = 1'b1;
            end
          end
          // No filled slot: the head block itself is handed out.
          if (!hit) begin
            link = rd_word(head_blk, 0);
            exp.granted_id = head_blk;
            if (link == head_blk) begin
              free_cnt = '0;
              head_ok  = 1'b0;
              head_blk = '0;
            end else begin
              head_blk = link;
            end
          end
          if (exp.granted_id > limit) exp.status = ST_CORRUPT;
        end
      end else begin
        if (!head_ok || free_cnt == 0) begin
          free_cnt = CntW'(1);
          head_blk = r.blk_id;
          head_ok  = 1'b1;
          build_head(r.blk_id, r.blk_id);
        end else begin
          for (int w = 1; w < Entries && !hit; w++) begin
            if (rd_word(head_blk, w) == '0) begin
              wr_word(head_blk, w, r.blk_id);
              hit = 1'b1;
            end
          end
          if (!hit) begin
            build_head(r.blk_id, head_blk);
            head_blk = r.blk_id;
          end
          free_cnt = free_cnt + CntW'(1);
        end
      end
      pending_grants.push_back(exp);
    endfunction

    function void flag(string what, rsp_t exp, rsp_t got);
      if (fail_cnt < MaxReports)
        $display("%0t: %s: expected id %0d status %0d, got id %0d status %0d",
                 $realtime, what, exp.granted_id, exp.status, got.granted_id,
                 got.status);
      fail_cnt++;
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      if (pending_grants.size() == 0) begin
        flag("response with no command outstanding", '0, got);
        return;
      end
      exp = pending_grants.pop_front();
      if (got.granted_id !== exp.granted_id || got.status !== exp.status)
        flag("response mismatch", exp, got);
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni      = 1'b0;
  logic           start       = 1'b0;
  logic           busy;
  req_t           req_i       = '0;
  logic           done_o;
  rsp_t           rsp_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [IdW-1:0] cfg_data_i  = '0;

  alloc_checker grants;
  int unsigned  stall_cycles = 0;

  grouped_free_block_allocator #(
    .BLOCKS (BlocksDef),
    .ENTRIES(EntriesDef)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) grants.check_result(rsp_o);
  end

  // Any beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogMax) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic req_t make_req(logic cmd, logic [IdW-1:0] id);
    req_t r;
    r.cmd    = cmd;
    r.blk_id = id;
    return r;
  endfunction

  // Half of the ids come from a small pool so that blocks are reused and chains
  // grow several index blocks deep.
  function automatic req_t pick_req(int unsigned free_pct, logic [IdW-1:0] lim);
    req_t r;
    r.cmd = ($urandom_range(99) < free_pct) ? CMD_FREE : CMD_ALLOC;
    case ($urandom_range(9))
      0:       r.blk_id = '0;
      1:       r.blk_id = '1;
      2, 3:    r.blk_id = IdW'($urandom_range(1023));
      4:       r.blk_id = (lim == '1) ? IdW'($urandom_range(1023))
                                      : IdW'($urandom_range(1023, lim + 1));
      default: r.blk_id = IdW'($urandom_range(48, 1));
    endcase
    return r;
  endfunction

  task automatic send(req_t r, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    grants.note_request(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (grants.pending() != 0) @(posedge clk_i);
  endtask

  // The limit is only written once nothing is in flight, after a settle pause.
  task automatic write_limit(logic [IdW-1:0] v);
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    grants.set_limit(v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    write_limit(NumBlocksRst);
    send(make_req(CMD_ALLOC, '0), 0);
    send(make_req(CMD_FREE, 10'd5), 0);
    send(make_req(CMD_FREE, '0), 0);
    send(make_req(CMD_FREE, '1), 0);
    send(make_req(CMD_ALLOC, '1), 0);
    send(make_req(CMD_ALLOC, '0), 0);
    // Fill the head block, then free the head itself while it is full.
    for (int i = 1; i <= Entries; i++) send(make_req(CMD_FREE, IdW'(i)), 0);
    send(make_req(CMD_FREE, 10'd1), 0);
    send(make_req(CMD_ALLOC, '0), 0);
    write_limit(10'd1);
    send(make_req(CMD_FREE, 10'd9), 0);
    send(make_req(CMD_FREE, '1), 0);
    send(make_req(CMD_ALLOC, '0), 0);
    send(make_req(CMD_ALLOC, '0), 0);
  endtask

  task automatic run_phase(logic [IdW-1:0] lim, bit quiet);
    int unsigned burst_left;
    int unsigned free_pct;
    int unsigned gap;
    bit          idle_on;
    burst_left = 0;
    free_pct   = 50;
    idle_on    = 1'b0;
    write_limit(lim);
    for (int n = 0; n < PhaseItems; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(60, 15);
        case ($urandom_range(2))
          0:       free_pct = 80;
          1:       free_pct = 25;
          default: free_pct = 50;
        endcase
        idle_on = !quiet && ($urandom_range(2) != 0);
      end
      burst_left--;
      gap = (idle_on && $urandom_range(2) == 0) ? $urandom_range(6, 1) : 0;
      send(pick_req(free_pct, lim), gap);
      if (!quiet && $urandom_range(49) == 0) drain();
    end
  endtask

  initial begin
    logic [IdW-1:0] limits [8];
    grants = new();
    limits[0] = NumBlocksRst;
    limits[1] = 10'd1;
    limits[2] = 10'd40;
    limits[3] = IdW'($urandom_range(1023, 1));
    limits[4] = NumBlocksRst;
    limits[5] = 10'd517;
    limits[6] = IdW'($urandom_range(1023, 1));
    limits[7] = NumBlocksRst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 8; p++) run_phase(limits[p], p == 7);
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (grants.fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
